// ----- src/lz10_lz11_stream_decompressor_unit_defines.svh -----
// ---------------------------------------------------------------------------
// LZ10/LZ11 decompressor assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LZ10_LZ11_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ10_LZ11_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LZD_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LZD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LZD_ASSERT_SAME(name, clk, rst, ante, cons, msg)
`define LZD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/lzd_pkg.sv -----
// ---------------------------------------------------------------------------
// LZ10/LZ11 decompressor package
// Shared item types, codes and default sizes.
// ---------------------------------------------------------------------------
package lzd_pkg;

   localparam int HISTORY_DEPTH_DEF = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_END     = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_FORMAT  = 3'd2;
   localparam logic [2:0] ST_BIG     = 3'd3;
   localparam logic [2:0] ST_OVERRUN = 3'd4;
   localparam logic [2:0] ST_DIST    = 3'd5;
   localparam logic [2:0] ST_TRUNC   = 3'd6;
   localparam logic [2:0] ST_BUSY    = 3'd7;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [2:0] status;
      logic       last;
   } rsp_item_type;

endpackage

// ----- src/lz10_lz11_stream_decompressor_unit.sv -----
// Each accepted item is parsed and registered in the engine, then pushed into the output queue.
// Throughput: one item per cycle, literals and copy ticks alike, while the output queue has room
// for the result, set by the one read and one write port of the history RAM.
// Reset: synchronous, active high; clears parser state and both queues and sets
// the capacity to its maximum. History contents are not cleared.
// ---------------------------------------------------------------------------
// LZ10/LZ11 stream decompressor
// Input queue feeding the parsing engine, whose results drain into an output queue.
// ---------------------------------------------------------------------------
module lz10_lz11_stream_decompressor_unit
   import lzd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata
);

   localparam int IW = $bits(req_item_type);
   localparam int RW = $bits(rsp_item_type);
   localparam int CW = $clog2(QUEUE_DEPTH+1);

   req_item_type  req_item, eng_item;
   rsp_item_type  eng_rsp, rsp_item;
   logic          in_full, in_empty, eng_take, eng_push, out_full;
   logic [IW-1:0] in_rd;
   logic [RW-1:0] out_rd;
   logic [CW-1:0] in_count, out_count;
   logic [23:0]   cap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 24'hFFFFFF;
      end else if (csr_valid) begin
         cap_ff <= csr_wdata;
      end
   end

   assign req_item.action  = req_action;
   assign req_item.in_byte = req_in_byte;
   assign req_full         = in_full;
   assign eng_item         = req_item_type'(in_rd);

   lzd_fifo #(.DATA_W(IW), .DEPTH(QUEUE_DEPTH)) u_in_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_item),
      .pop     (eng_take),
      .rd_data (in_rd),
      .full    (in_full),
      .empty   (in_empty),
      .count   (in_count)
   );

   lzd_engine #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_avail  (!in_empty && (in_count != '0)),
      .in_item   (eng_item),
      .in_take   (eng_take),
      .out_count (out_count),
      .out_push  (eng_push),
      .out_item  (eng_rsp),
      .capacity  (cap_ff)
   );

   lzd_fifo #(.DATA_W(RW), .DEPTH(QUEUE_DEPTH)) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (eng_push),
      .wr_data (eng_rsp),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .full    (out_full),
      .empty   (rsp_empty),
      .count   (out_count)
   );

   assign rsp_item      = rsp_item_type'(out_rd);
   assign rsp_out_byte  = rsp_item.out_byte;
   assign rsp_out_valid = rsp_item.out_valid && !out_full | rsp_item.out_valid;
   assign rsp_status    = rsp_item.status;
   assign rsp_last      = rsp_item.last;

endmodule

// ----- src/lzd_fifo.sv -----
// ---------------------------------------------------------------------------
// LZ decompressor queue
// Small first-in first-out queue of items with an occupancy count.
// ---------------------------------------------------------------------------
module lzd_fifo
   import lzd_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/lzd_engine.sv -----
// ---------------------------------------------------------------------------
// LZ decompressor engine
// Parses the stream and issues history reads, then forms each result item.
// ---------------------------------------------------------------------------
`include "lz10_lz11_stream_decompressor_unit_defines.svh"
module lzd_engine
   import lzd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int OUT_DEPTH     = QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_avail,
   input  req_item_type                   in_item,
   output logic                           in_take,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output rsp_item_type                   out_item,
   input  logic [23:0]                    capacity
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(OUT_DEPTH+1);

   localparam logic [3:0] PH_HDR0  = 4'd0;
   localparam logic [3:0] PH_HDR1  = 4'd1;
   localparam logic [3:0] PH_HDR2  = 4'd2;
   localparam logic [3:0] PH_HDR3  = 4'd3;
   localparam logic [3:0] PH_FLAGS = 4'd4;
   localparam logic [3:0] PH_LIT   = 4'd5;
   localparam logic [3:0] PH_L10A  = 4'd6;
   localparam logic [3:0] PH_L10B  = 4'd7;
   localparam logic [3:0] PH_L11A  = 4'd8;
   localparam logic [3:0] PH_L11S  = 4'd9;
   localparam logic [3:0] PH_L11M  = 4'd10;
   localparam logic [3:0] PH_L11N  = 4'd11;
   localparam logic [3:0] PH_L11D  = 4'd12;
   localparam logic [3:0] PH_COPY  = 4'd13;

   logic [AW-1:0] wp_ff, wp_in;
   logic [23:0]   prod_ff, prod_in, target_ff, target_in;
   logic          fmt_ff, fmt_in;
   logic [3:0]    phase_ff, phase_in;
   logic [7:0]    flags_ff, flags_in;
   logic [3:0]    fleft_ff, fleft_in;
   logic [15:0]   hold_ff, hold_in;
   logic [16:0]   cleft_ff, cleft_in;
   logic [12:0]   cdist_ff, cdist_in;
   logic [2:0]    outcome_ff, outcome_in;

   logic          b_valid_ff, b_copy_ff, b_fwd_ff, b_wr_ff, b_last_ff;
   logic [AW-1:0] b_addr_ff;
   logic [7:0]    b_lit_ff, rdata_ff, last_byte_ff, b_byte;
   logic [2:0]    b_status_ff;

   logic          a_copy, a_wr, a_last, a_busy, a_fwd;
   logic [AW:0]   t_wide;
   logic [AW-1:0] t_addr;
   logic [15:0]   v16;
   logic [3:0]    nib;
   logic [24:0]   room;
   logic [12:0]   span;
   logic [16:0]   count;

   assign in_take = in_avail && ((out_count + CW'(b_valid_ff)) < CW'(OUT_DEPTH));

   always_comb begin
      if ({1'b0, wp_ff} >= (AW+1)'(cdist_ff)) begin
         t_wide = {1'b0, wp_ff} - (AW+1)'(cdist_ff);
      end else begin
         t_wide = {1'b0, wp_ff} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cdist_ff);
      end
      t_addr = t_wide[AW-1:0];
   end

   always_comb begin
      wp_in      = wp_ff;
      prod_in    = prod_ff;
      target_in  = target_ff;
      fmt_in     = fmt_ff;
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      fleft_in   = fleft_ff;
      hold_in    = hold_ff;
      cleft_in   = cleft_ff;
      cdist_in   = cdist_ff;
      outcome_in = outcome_ff;
      a_copy     = 1'b0;
      a_wr       = 1'b0;
      a_busy     = 1'b0;
      v16        = {hold_ff[7:0], in_item.in_byte};
      nib        = in_item.in_byte[7:4];
      room       = {1'b0, target_ff} - {1'b0, prod_ff};
      span       = '0;
      count      = '0;
      unique case (in_item.action)
         ACT_RESTART: begin
            wp_in      = '0;
            prod_in    = '0;
            target_in  = '0;
            fmt_in     = 1'b0;
            phase_in   = PH_HDR0;
            flags_in   = '0;
            fleft_in   = '0;
            hold_in    = '0;
            cleft_in   = '0;
            cdist_in   = '0;
            outcome_in = ST_RUN;
         end
         ACT_END: begin
            if (outcome_ff == ST_RUN && !(phase_ff == PH_COPY &&
                ({1'b0, prod_ff} + 25'(cleft_ff)) == {1'b0, target_ff})) begin
               outcome_in = ST_TRUNC;
               cleft_in   = '0;
            end
         end
         ACT_TICK: begin
            if (outcome_ff == ST_RUN && phase_ff == PH_COPY && cleft_ff != '0) begin
               a_copy   = 1'b1;
               a_wr     = 1'b1;
               wp_in    = (wp_ff == AW'(HISTORY_DEPTH-1)) ? '0 : wp_ff + 1'b1;
               prod_in  = prod_ff + 1'b1;
               cleft_in = cleft_ff - 1'b1;
               if (cleft_in == '0) begin
                  if (prod_in == target_ff) begin
                     outcome_in = ST_DONE;
                  end else if (fleft_ff == '0) begin
                     phase_in = PH_FLAGS;
                  end else begin
                     flags_in = {flags_ff[6:0], 1'b0};
                     fleft_in = fleft_ff - 1'b1;
                     phase_in = !flags_ff[7] ? PH_LIT : (fmt_ff ? PH_L11A : PH_L10A);
                  end
               end
            end
         end
         default: begin
            if (outcome_ff == ST_RUN) begin
               unique case (phase_ff)
                  PH_HDR0: begin
                     hold_in   = 16'(in_item.in_byte);
                     target_in = '0;
                     phase_in  = PH_HDR1;
                  end
                  PH_HDR1: begin
                     target_in = target_ff | 24'(in_item.in_byte);
                     phase_in  = PH_HDR2;
                  end
                  PH_HDR2: begin
                     target_in = target_ff | {8'd0, in_item.in_byte, 8'd0};
                     phase_in  = PH_HDR3;
                  end
                  PH_HDR3: begin
                     target_in = target_ff | {in_item.in_byte, 16'd0};
                     if (target_in > capacity) begin
                        outcome_in = ST_BIG;
                     end else if (hold_ff != 16'h0010 && hold_ff != 16'h0011) begin
                        outcome_in = ST_FORMAT;
                     end else begin
                        fmt_in = (hold_ff == 16'h0011);
                        if (target_in == '0) begin
                           outcome_in = ST_DONE;
                        end else begin
                           phase_in = PH_FLAGS;
                        end
                     end
                  end
                  PH_FLAGS: begin
                     flags_in = {in_item.in_byte[6:0], 1'b0};
                     fleft_in = 4'd7;
                     phase_in = !in_item.in_byte[7] ? PH_LIT : (fmt_ff ? PH_L11A : PH_L10A);
                  end
                  PH_LIT: begin
                     a_wr    = 1'b1;
                     wp_in   = (wp_ff == AW'(HISTORY_DEPTH-1)) ? '0 : wp_ff + 1'b1;
                     prod_in = prod_ff + 1'b1;
                     if (prod_in == target_ff) begin
                        outcome_in = ST_DONE;
                     end else if (fleft_ff == '0) begin
                        phase_in = PH_FLAGS;
                     end else begin
                        flags_in = {flags_ff[6:0], 1'b0};
                        fleft_in = fleft_ff - 1'b1;
                        phase_in = !flags_ff[7] ? PH_LIT : (fmt_ff ? PH_L11A : PH_L10A);
                     end
                  end
                  PH_L10A: begin
                     hold_in  = 16'(in_item.in_byte);
                     phase_in = PH_L10B;
                  end
                  PH_L11A: begin
                     if (nib == 4'd0) begin
                        cleft_in = 17'({in_item.in_byte[3:0], 4'd0});
                        phase_in = PH_L11S;
                     end else if (nib == 4'd1) begin
                        cleft_in = {1'b0, in_item.in_byte[3:0], 12'd0};
                        phase_in = PH_L11M;
                     end else begin
                        cleft_in = 17'(nib) + 17'd1;
                        cdist_in = 13'(in_item.in_byte[3:0]);
                        phase_in = PH_L11D;
                     end
                  end
                  PH_L11S: begin
                     cleft_in = (cleft_ff | 17'(nib)) + 17'd17;
                     cdist_in = 13'(in_item.in_byte[3:0]);
                     phase_in = PH_L11D;
                  end
                  PH_L11M: begin
                     cleft_in = cleft_ff | {5'd0, in_item.in_byte, 4'd0};
                     phase_in = PH_L11N;
                  end
                  PH_L11N: begin
                     cleft_in = (cleft_ff | 17'(nib)) + 17'd273;
                     cdist_in = 13'(in_item.in_byte[3:0]);
                     phase_in = PH_L11D;
                  end
                  PH_COPY: begin
                     a_busy = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (phase_ff == PH_L10B || phase_ff == PH_L11D) begin
                  if (phase_ff == PH_L10B) begin
                     count = 17'd3 + 17'(v16[15:12]);
                     span  = 13'd1 + 13'(v16[11:0]);
                  end else begin
                     count = cleft_ff;
                     span  = {1'b0, cdist_ff[3:0], in_item.in_byte} + 13'd1;
                  end
                  cleft_in = '0;
                  if (25'(count) > room) begin
                     outcome_in = ST_OVERRUN;
                  end else if (24'(span) > prod_ff) begin
                     outcome_in = ST_DIST;
                  end else begin
                     cleft_in = count;
                     cdist_in = span;
                     phase_in = PH_COPY;
                  end
               end
            end
         end
      endcase
      a_last = a_wr && (outcome_in == ST_DONE);
      a_fwd  = b_valid_ff && b_wr_ff && (b_addr_ff == t_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         prod_ff    <= '0;
         target_ff  <= '0;
         fmt_ff     <= 1'b0;
         phase_ff   <= PH_HDR0;
         flags_ff   <= '0;
         fleft_ff   <= '0;
         hold_ff    <= '0;
         cleft_ff   <= '0;
         cdist_ff   <= '0;
         outcome_ff <= ST_RUN;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= in_take;
         if (in_take) begin
            wp_ff      <= wp_in;
            prod_ff    <= prod_in;
            target_ff  <= target_in;
            fmt_ff     <= fmt_in;
            phase_ff   <= phase_in;
            flags_ff   <= flags_in;
            fleft_ff   <= fleft_in;
            hold_ff    <= hold_in;
            cleft_ff   <= cleft_in;
            cdist_ff   <= cdist_in;
            outcome_ff <= outcome_in;
         end
      end
   end

   logic [7:0] hist_mem [HISTORY_DEPTH];

   always_ff @(posedge clock) begin
      if (in_take) begin
         rdata_ff    <= hist_mem[t_addr];
         b_copy_ff   <= a_copy;
         b_fwd_ff    <= a_fwd;
         b_wr_ff     <= a_wr;
         b_last_ff   <= a_last;
         b_addr_ff   <= wp_ff;
         b_lit_ff    <= in_item.in_byte;
         b_status_ff <= a_busy ? ST_BUSY : outcome_in;
      end
      if (b_valid_ff && b_wr_ff) begin
         hist_mem[b_addr_ff] <= b_byte;
         last_byte_ff        <= b_byte;
      end
   end

   always_comb begin
      if (!b_wr_ff) begin
         b_byte = '0;
      end else if (b_copy_ff) begin
         b_byte = b_fwd_ff ? last_byte_ff : rdata_ff;
      end else begin
         b_byte = b_lit_ff;
      end
      out_push           = b_valid_ff;
      out_item.out_byte  = b_byte;
      out_item.out_valid = b_wr_ff;
      out_item.status    = b_status_ff;
      out_item.last      = b_last_ff;
   end

   `LZD_ASSERT_SAME(a_copy_pending, clock, reset, (outcome_ff == ST_RUN && phase_ff == PH_COPY), (cleft_ff != '0), "Copy phase entered with nothing left to copy.")
   `LZD_ASSERT_SAME(a_prod_bound, clock, reset, (outcome_ff == ST_RUN && phase_ff >= PH_FLAGS), (prod_ff <= target_ff), "More bytes produced than the header size.")
   `LZD_ASSERT_NEXT(a_tick_emits, clock, reset, (in_take && a_copy), (b_valid_ff && out_item.out_valid), "A copy tick did not yield a byte.")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LZ10/LZ11 stream decompressor testbench
// Drives directed and random compressed streams through the input queue,
// predicts every result item and checks each popped result against it.
// ---------------------------------------------------------------------------
module tb
   import lzd_pkg::*;
();

   localparam int HIST_SIZE = 4096;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 40;

   typedef enum logic [3:0] {
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_FLAGS, PH_LIT, PH_L10A, PH_L10B,
      PH_L11A, PH_L11S, PH_L11M, PH_L11N, PH_L11D, PH_COPY
   } parse_phase_type;

   class lz_scoreboard_type;
      logic [7:0]      hist [HIST_SIZE];
      int unsigned     wr_pos, produced, target, copy_left, copy_dist, hold, cap;
      bit              is_lz11;
      parse_phase_type phase;
      logic [7:0]      flag_bits;
      int unsigned     flags_left;
      logic [2:0]      outcome;
      rsp_item_type    expected_q [$];
      int              errors;

      function new();
         foreach (hist[i]) hist[i] = 8'h00;
         cap = 24'hFFFFFF;
         errors = 0;
         clear();
      endfunction

      function void clear();
         wr_pos = 0; produced = 0; target = 0; is_lz11 = 0; phase = PH_HDR0;
         flag_bits = 0; flags_left = 0; hold = 0; copy_left = 0; copy_dist = 0;
         outcome = ST_RUN;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit(logic [7:0] b);
         hist[wr_pos] = b;
         wr_pos = (wr_pos + 1) % HIST_SIZE;
         produced = (produced + 1) & 24'hFFFFFF;
      endfunction

      function void take_flag();
         bit f;
         if (flags_left == 0) begin
            phase = PH_FLAGS;
            return;
         end
         f = flag_bits[7];
         flag_bits = flag_bits << 1;
         flags_left--;
         phase = !f ? PH_LIT : (is_lz11 ? PH_L11A : PH_L10A);
      endfunction

      function void unit_finished();
         if (produced == target) outcome = ST_DONE;
         else take_flag();
      endfunction

      function void begin_copy(int unsigned len, int unsigned span);
         copy_left = 0;
         if (len > target - produced) outcome = ST_OVERRUN;
         else if (span > produced) outcome = ST_DIST;
         else begin
            copy_left = len;
            copy_dist = span;
            phase = PH_COPY;
         end
      endfunction

      function void note(logic [1:0] act, logic [7:0] b);
         rsp_item_type r;
         int unsigned t, v;
         bit busy;
         r = '0;
         busy = 0;
         if (act == ACT_RESTART) begin
            clear();
         end else if (act == ACT_END) begin
            if (outcome == ST_RUN &&
                !(phase == PH_COPY && produced + copy_left == target)) begin
               outcome = ST_TRUNC;
               copy_left = 0;
            end
         end else if (act == ACT_TICK) begin
            if (outcome == ST_RUN && phase == PH_COPY && copy_left != 0) begin
               t = (wr_pos + HIST_SIZE - copy_dist) % HIST_SIZE;
               r.out_byte = hist[t];
               r.out_valid = 1'b1;
               emit(hist[t]);
               copy_left--;
               if (copy_left == 0) unit_finished();
               r.last = (outcome == ST_DONE);
            end
         end else if (outcome == ST_RUN) begin
            case (phase)
               PH_HDR0: begin hold = b; target = 0; phase = PH_HDR1; end
               PH_HDR1: begin target |= b; phase = PH_HDR2; end
               PH_HDR2: begin target |= int'(b) << 8; phase = PH_HDR3; end
               PH_HDR3: begin
                  target |= int'(b) << 16;
                  if (target > cap) outcome = ST_BIG;
                  else if (hold != 'h10 && hold != 'h11) outcome = ST_FORMAT;
                  else begin
                     is_lz11 = (hold == 'h11);
                     if (target == 0) outcome = ST_DONE;
                     else phase = PH_FLAGS;
                  end
               end
               PH_FLAGS: begin flag_bits = b; flags_left = 8; take_flag(); end
               PH_LIT: begin
                  r.out_byte = b;
                  r.out_valid = 1'b1;
                  emit(b);
                  unit_finished();
                  r.last = (outcome == ST_DONE);
               end
               PH_L10A: begin hold = b; phase = PH_L10B; end
               PH_L10B: begin
                  v = ((hold & 'hFF) << 8) | b;
                  begin_copy(3 + (v >> 12), 1 + (v & 'hFFF));
               end
               PH_L11A: begin
                  t = b >> 4;
                  if (t == 0) begin
                     copy_left = (b & 'hF) << 4; phase = PH_L11S;
                  end else if (t == 1) begin
                     copy_left = (b & 'hF) << 12; phase = PH_L11M;
                  end else begin
                     copy_left = 1 + t; copy_dist = b & 'hF; phase = PH_L11D;
                  end
               end
               PH_L11S: begin
                  copy_left = (copy_left | (b >> 4)) + 17;
                  copy_dist = b & 'hF; phase = PH_L11D;
               end
               PH_L11M: begin copy_left |= int'(b) << 4; phase = PH_L11N; end
               PH_L11N: begin
                  copy_left = (copy_left | (b >> 4)) + 273;
                  copy_dist = b & 'hF; phase = PH_L11D;
               end
               PH_L11D: begin_copy(copy_left, (((copy_dist & 'hF) << 8) | b) + 1);
               PH_COPY: busy = 1;
               default: ;
            endcase
         end
         r.status = busy ? ST_BUSY : outcome;
         expected_q.push_back(r);
      endfunction

      function void compare(string name, int e, int a);
         if (e != a) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check(rsp_item_type got);
         rsp_item_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result item: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare("out_byte", e.out_byte, got.out_byte);
         compare("out_valid", e.out_valid, got.out_valid);
         compare("status", e.status, got.status);
         compare("last", e.last, got.last);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_action;
   logic [7:0]  req_in_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_wdata;

   lz_scoreboard_type sb;
   bit quiet;
   bit hold_req;
   bit hold_done;
   int sent;
   int stall_count;

   lz10_lz11_stream_decompressor_unit i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_in_byte(req_in_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_out_valid(rsp_out_valid),
      .rsp_status(rsp_status), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic send(logic [1:0] act, logic [7:0] b);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= act;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      sb.note(act, b);
      sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [23:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.cap = value;
   endtask

   task automatic send_header(logic [7:0] fmt, int unsigned size);
      send(ACT_BYTE, fmt);
      send(ACT_BYTE, size[7:0]);
      send(ACT_BYTE, size[15:8]);
      send(ACT_BYTE, size[23:16]);
   endtask

   task automatic send_token();
      int unsigned remaining, len, span, d, n, top, r;
      remaining = sb.target - sb.produced;
      r = $urandom_range(0, 7);
      if (!sb.is_lz11) top = 18;
      else if (r < 5) top = 16;
      else if (r < 7) top = 272;
      else top = 600;
      if ($urandom_range(0, 29) == 0) len = $urandom_range(3, top);
      else if (remaining < 3) len = 3;
      else len = $urandom_range(3, top < remaining ? top : remaining);
      if (sb.is_lz11 && r >= 5 && len <= 16 && remaining >= 17)
         len = 17;
      top = sb.produced < HIST_SIZE ? sb.produced : HIST_SIZE;
      if (top == 0 || $urandom_range(0, 39) == 0) span = top + 1;
      else if ($urandom_range(0, 3) == 0) span = top;
      else span = $urandom_range(1, top);
      if (span > HIST_SIZE) span = HIST_SIZE;
      d = span - 1;
      if (!sb.is_lz11) begin
         send(ACT_BYTE, 8'(((len - 3) << 4) | (d >> 8)));
      end else if (len <= 16) begin
         send(ACT_BYTE, 8'(((len - 1) << 4) | (d >> 8)));
      end else if (len <= 272) begin
         n = len - 17;
         send(ACT_BYTE, 8'(n >> 4));
         send(ACT_BYTE, 8'(((n & 'hF) << 4) | (d >> 8)));
      end else begin
         n = len - 273;
         send(ACT_BYTE, 8'('h10 | (n >> 12)));
         send(ACT_BYTE, 8'(n >> 4));
         send(ACT_BYTE, 8'(((n & 'hF) << 4) | (d >> 8)));
      end
      send(ACT_BYTE, 8'(d & 'hFF));
   endtask

   task automatic run_stream(int unsigned size);
      int unsigned r;
      r = $urandom_range(0, 19);
      send_header(r == 0 ? 8'($urandom) : (r < 10 ? 8'h10 : 8'h11), size);
      while (sb.outcome == ST_RUN && sb.phase >= PH_FLAGS) begin
         r = $urandom_range(0, 99);
         if (r == 0) send(ACT_END, 8'($urandom));
         else if (r == 1) send(ACT_RESTART, 8'($urandom));
         else if (sb.phase == PH_COPY) begin
            if (r < 6) send(ACT_BYTE, 8'($urandom));
            else send(ACT_TICK, 8'($urandom));
         end else if (sb.phase == PH_L10A || sb.phase == PH_L11A) begin
            send_token();
         end else begin
            send(ACT_BYTE, 8'($urandom));
         end
      end
      if ($urandom_range(0, 3) == 0) send(2'($urandom), 8'($urandom));
      send(ACT_RESTART, 8'h00);
   endtask

   task automatic run_random(int unsigned items);
      int unsigned start, size;
      start = sent;
      while (sent - start < items) begin
         case ($urandom_range(0, 9))
            0: size = $urandom_range(100, 700);
            1: size = $urandom_range(0, 2);
            default: size = $urandom_range(1, 40);
         endcase
         run_stream(size);
      end
   endtask

   initial begin
      rsp_pop <= 1'b0;
      idle_loop : forever begin
         int idle_left;
         idle_left = 0;
         forever begin
            @(posedge clock);
            if (rsp_pop && !rsp_empty)
               sb.check('{rsp_out_byte, rsp_out_valid, rsp_status, rsp_last});
            if (idle_left > 0) begin
               idle_left--;
               rsp_pop <= 1'b0;
            end else if (hold_req && !hold_done) begin
               hold_done = 1;
               idle_left = HOLD_CYCLES;
               rsp_pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               idle_left = $urandom_range(0, 4);
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= !reset;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)
          || reset)
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count > WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      sb = new();
      quiet = 0;
      hold_req = 0;
      sent = 0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_action <= ACT_BYTE;
      req_in_byte <= 8'h00;
      csr_valid <= 1'b0;
      csr_wdata <= 24'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, short LZ10 stream with busy byte, then bad-format, empty and truncated streams.
      send(ACT_TICK, 8'h00);
      send_header(8'h10, 5);
      send(ACT_BYTE, 8'h40);
      send(ACT_BYTE, 8'hFF);
      send(ACT_BYTE, 8'h00);
      send(ACT_BYTE, 8'h00);
      send(ACT_BYTE, 8'h5A);
      repeat (3) send(ACT_TICK, 8'h00);
      send(ACT_BYTE, 8'h00);
      send(ACT_BYTE, 8'hAA);
      send(ACT_END, 8'h00);
      send(ACT_RESTART, 8'h00);
      send_header(8'h12, 1);
      send(ACT_RESTART, 8'h00);
      send_header(8'h11, 0);
      send(ACT_RESTART, 8'h00);
      send_header(8'h10, 2);
      send(ACT_END, 8'h00);
      send(ACT_RESTART, 8'h00);

      write_capacity(24'hFFFFFF);
      run_random(250);
      hold_req = 1;
      run_random(60);
      drain();
      run_random(100);

      write_capacity(24'd0);
      run_random(40);

      write_capacity(24'($urandom_range(1, 60)));
      run_random(120);

      write_capacity(24'hFFFFFF);
      quiet = 1;
      run_random(150);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
